// ----- src/usan_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// usan_pkg
// Shared types and constants for the UTF-8 byte sanitizer.
// ----------------------------------------------------------------------------
package usan_pkg;

   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_CODE  = 8'h80;
   localparam logic [7:0] ASCII_MAX  = 8'd127;
   localparam logic [7:0] PRINT_LO   = 8'd32;
   localparam logic [7:0] PRINT_HI   = 8'd126;
   localparam logic [7:0] CHAR_TAB   = 8'd9;
   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] LEAD2_LO   = 8'd192;
   localparam logic [7:0] LEAD2_HI   = 8'd223;
   localparam logic [7:0] LEAD3_LO   = 8'd224;
   localparam logic [7:0] LEAD3_HI   = 8'd239;
   localparam logic [7:0] LEAD4_LO   = 8'd240;
   localparam logic [7:0] LEAD4_HI   = 8'd247;
   localparam int         MAX_BYTES  = 4;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       is_final;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       string_end;
      logic       run_last;
   } rsp_type;

   // one burst of results caused by a single request
   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] bytes;
      logic [1:0]                last_idx;
      logic                      marker;
      logic                      fin;
   } cmd_type;

   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } cmd_push_type;

endpackage
`default_nettype wire

// ----- src/usan_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// usan_front
// Classifies each request byte, tracks the open sequence, issues bursts.
// ----------------------------------------------------------------------------
module usan_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   accept,
   input  wire usan_pkg::req_type      req,
   output usan_pkg::cmd_push_type      cmd_out
);

   logic [2:0] seq_ff, seq_in;
   logic [1:0] cnt_ff, cnt_in;
   logic [7:0] held_ff [3];
   logic [7:0] held_in [3];

   logic [7:0] b;
   logic       is_cont;
   logic       keep_ascii;
   logic [2:0] lead_len;
   logic [2:0] n;
   logic       fresh;
   logic [usan_pkg::MAX_BYTES-1:0][7:0] bytes;

   always_comb begin
      b       = req.in_byte;
      is_cont = (b & usan_pkg::CONT_MASK) == usan_pkg::CONT_CODE;
      keep_ascii = (b >= usan_pkg::PRINT_LO && b <= usan_pkg::PRINT_HI) ||
                   b == usan_pkg::CHAR_TAB || b == usan_pkg::CHAR_LF ||
                   b == usan_pkg::CHAR_CR;
      priority if (b >= usan_pkg::LEAD2_LO && b <= usan_pkg::LEAD2_HI) begin
         lead_len = 3'd2;
      end else if (b >= usan_pkg::LEAD3_LO && b <= usan_pkg::LEAD3_HI) begin
         lead_len = 3'd3;
      end else if (b >= usan_pkg::LEAD4_LO && b <= usan_pkg::LEAD4_HI) begin
         lead_len = 3'd4;
      end else begin
         lead_len = 3'd0;
      end

      seq_in  = seq_ff;
      cnt_in  = cnt_ff;
      held_in = held_ff;
      n       = 3'd0;
      fresh   = 1'b1;
      bytes   = '0;

      if (seq_ff != 3'd0) begin
         if (is_cont) begin
            fresh = 1'b0;
            if (({1'b0, cnt_ff} + 3'd1) >= seq_ff) begin
               // sequence complete: held bytes then this one
               for (int i = 0; i < 3; i++) begin
                  if (2'(i) < cnt_ff) begin
                     bytes[i] = held_ff[i];
                  end
               end
               bytes[cnt_ff] = b;
               n      = {1'b0, cnt_ff} + 3'd1;
               seq_in = 3'd0;
               cnt_in = 2'd0;
            end else if (cnt_ff < 2'd3) begin
               held_in[cnt_ff] = b;
               cnt_in = cnt_ff + 2'd1;
            end else begin
               seq_in = 3'd0;
               cnt_in = 2'd0;
            end
         end else begin
            seq_in = 3'd0;
            cnt_in = 2'd0;
         end
      end

      if (fresh) begin
         if (b <= usan_pkg::ASCII_MAX) begin
            if (keep_ascii) begin
               bytes[0] = b;
               n = 3'd1;
            end
         end else if (lead_len != 3'd0) begin
            held_in[0] = b;
            cnt_in = 2'd1;
            seq_in = lead_len;
         end
      end

      if (req.is_final) begin
         seq_in = 3'd0;
         cnt_in = 2'd0;
      end

      cmd_out.cmd.bytes    = bytes;
      cmd_out.cmd.marker   = (n == 3'd0);
      cmd_out.cmd.last_idx = (n == 3'd0) ? 2'd0 : 2'(n - 3'd1);
      cmd_out.cmd.fin      = req.is_final;
      cmd_out.push         = accept && (n != 3'd0 || req.is_final);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= 3'd0;
         cnt_ff <= 2'd0;
      end else if (accept) begin
         seq_ff <= seq_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

endmodule
`default_nettype wire

// ----- src/usan_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// usan_queue
// Small FIFO of result bursts between front and back.
// ----------------------------------------------------------------------------
module usan_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire usan_pkg::cmd_push_type wr,
   output logic                        full,
   input  wire logic                   rd,
   output logic                        empty,
   output usan_pkg::cmd_type           head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   usan_pkg::cmd_type mem [DEPTH];
   logic [PW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          do_wr, do_rd;

   assign full  = (cnt_ff == CW'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = mem[rp_ff];

   always_comb begin
      do_wr = wr.push && !full;
      do_rd = rd && !empty;
      wp_in = wp_ff;
      rp_in = rp_ff;
      if (do_wr) begin
         wp_in = (wp_ff == PW'(DEPTH - 1)) ? '0 : wp_ff + PW'(1);
      end
      if (do_rd) begin
         rp_in = (rp_ff == PW'(DEPTH - 1)) ? '0 : rp_ff + PW'(1);
      end
      cnt_in = cnt_ff + CW'(do_wr) - CW'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem[wp_ff] <= wr.cmd;
      end
   end

endmodule
`default_nettype wire

// ----- src/usan_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// usan_back
// Walks a burst one byte per cycle, unless stalled, into the response register.
// ----------------------------------------------------------------------------
module usan_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_empty,
   input  wire usan_pkg::cmd_type q_head,
   output logic                   q_pop,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output usan_pkg::rsp_type      rsp_data
);

   logic [1:0]        idx_ff, idx_in;
   logic              vld_ff, vld_in;
   usan_pkg::rsp_type out_ff, out_in;
   logic              load, last;

   always_comb begin
      load   = !vld_ff || rsp_pop;
      last   = (idx_ff == q_head.last_idx);
      q_pop  = load && !q_empty && last;
      idx_in = idx_ff;
      vld_in = vld_ff;
      out_in = out_ff;
      if (load) begin
         vld_in = !q_empty;
         if (!q_empty) begin
            out_in.out_byte   = q_head.marker ? 8'd0 : q_head.bytes[idx_ff];
            out_in.byte_valid = !q_head.marker;
            out_in.string_end = q_head.fin && last;
            out_in.run_last   = last;
            idx_in = last ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   assign rsp_empty = !vld_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
         vld_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule
`default_nettype wire

// ----- src/utf8_byte_sanitizer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_byte_sanitizer
// Streaming UTF-8 cleaner: keeps printable ASCII, tab, LF, CR and complete
// multi-byte sequences; drops everything else.
//
//   channel   ports                        direction
//   request   req_push req_full req_data   in  (one byte per request)
//   response  rsp_pop  rsp_empty rsp_data  out (0..4 results per request)
//
// A request is taken every cycle unless the burst queue is full.
// Responses leave one per cycle while rsp_pop is held; a completed 4-byte
// sequence goes out byte by byte via the back end's single response register.
// rsp_empty falls after the accepting edge once the burst has been written to the
// queue and then loaded into the response register.
// Synchronous reset clears sequence state, queue and response valid.
// ----------------------------------------------------------------------------
module utf8_byte_sanitizer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire usan_pkg::req_type req_data,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output usan_pkg::rsp_type      rsp_data
);

   usan_pkg::cmd_push_type cmd_push;
   usan_pkg::cmd_type      q_head;
   logic                   q_full, q_empty, q_pop;
   logic                   accept;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   usan_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req     (req_data),
      .cmd_out (cmd_push)
   );

   usan_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .wr    (cmd_push),
      .full  (q_full),
      .rd    (q_pop),
      .empty (q_empty),
      .head  (q_head)
   );

   usan_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
